// ===== hw/rtl/spims_pkg.sv =====
`default_nettype none

package spims_pkg;

   localparam int WORD_W     = 16;
   localparam int FRAME_W    = 5;
   localparam int SHIFT_W    = 4;
   localparam int HALF_W     = 16;
   localparam int MIN_FRAME  = 4;
   localparam int MAX_FRAME  = 16;

   localparam int FIFO_DEPTH = 8;
   localparam int DEPTH_W    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int SUM_W      = CNT_W + 1;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_READ  = 2'd2
   } spims_kind_type;

   typedef enum logic [2:0] {
      REG_FRAME_BITS    = 3'd0,
      REG_CLOCK_MODE    = 3'd1,
      REG_PRESCALE      = 3'd2,
      REG_CLOCK_DIVIDER = 3'd3,
      REG_ENABLE        = 3'd4
   } spims_reg_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_bits;
      logic               cpol;
      logic               cpha;
      logic [HALF_W-1:0]  half_ticks;
      logic               enable;
   } spims_cfg_type;

   typedef struct packed {
      logic sck;
      logic mosi;
      logic rx_not_empty;
      logic tx_not_full;
      logic busy;
      logic overrun;
   } spims_status_type;

   // ring index: head plus offset, wrapped at the FIFO depth
   function automatic logic [DEPTH_W-1:0] wrap_add(input logic [DEPTH_W-1:0] head,
                                                   input logic [CNT_W-1:0]   offs);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(offs);
      if (sum >= SUM_W'(FIFO_DEPTH)) begin
         sum = sum - SUM_W'(FIFO_DEPTH);
      end
      return DEPTH_W'(sum);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spi_master_serializer_unit.sv =====
// SPI master serializer. Takes one word per clock on the req_ channel (a tick, a
// transmit-FIFO write or a receive-FIFO read) while the response is not stalled, and
// returns one status word per request on the rsp_ channel, in order. Sustained rate
// is one request per cycle while rsp_ready stays high; each response passes through
// the registered read of the FIFO RAMs (transmit and receive FIFOs each live in a
// single-port-write RAM) followed by the output register. Configuration writes on
// the csr_ channel are accepted whenever reset is low and act on the next request.
`default_nettype none

module spi_master_serializer_unit (
   input  wire logic         clock,
   input  wire logic         reset,

   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [1:0]   req_kind,
   input  wire logic [15:0]  req_write_data,
   input  wire logic         req_miso,

   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic              rsp_sck,
   output logic              rsp_mosi,
   output logic      [15:0]  rsp_read_data,
   output logic              rsp_rx_not_empty,
   output logic              rsp_tx_not_full,
   output logic              rsp_busy_res,
   output logic              rsp_overrun,

   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [7:0]   csr_write_data
);

   logic [spims_pkg::FRAME_W-1:0] frame_ff, frame_in;
   logic [1:0]                    mode_ff, mode_in;
   logic [7:0]                    presc_ff, presc_in, div_ff, div_in;
   logic                          en_ff, en_in;
   logic [spims_pkg::HALF_W-1:0]  half_ff, half_in;
   logic [6:0]                    presc_half;
   logic                          csr_wr;

   spims_pkg::spims_cfg_type      cfg;
   spims_pkg::spims_status_type   status, rsp_st_ff;
   logic [spims_pkg::WORD_W-1:0]  core_rdata, rsp_rdata_ff;

   logic s2_valid_ff, s2_valid_in, rsp_valid_ff, rsp_valid_in;
   logic stall, s2_adv, accept;

   assign csr_ready = ~reset;
   assign csr_wr    = csr_valid & csr_ready;

   always_comb begin
      frame_in = frame_ff;
      mode_in  = mode_ff;
      presc_in = presc_ff;
      div_in   = div_ff;
      en_in    = en_ff;
      if (csr_wr) begin
         unique case (csr_index)
            spims_pkg::REG_FRAME_BITS:    frame_in = csr_write_data[spims_pkg::FRAME_W-1:0];
            spims_pkg::REG_CLOCK_MODE:    mode_in  = csr_write_data[1:0];
            spims_pkg::REG_PRESCALE:      presc_in = csr_write_data;
            spims_pkg::REG_CLOCK_DIVIDER: div_in   = csr_write_data;
            spims_pkg::REG_ENABLE:        en_in    = csr_write_data[0];
            default: ;
         endcase
      end
   end

   // half bit = (prescale/2, at least 1) * (divider + 1)
   assign presc_half = (presc_in[7:1] == '0) ? 7'd1 : presc_in[7:1];
   assign half_in    = spims_pkg::HALF_W'(presc_half) *
                       (spims_pkg::HALF_W'(div_in) + spims_pkg::HALF_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= spims_pkg::FRAME_W'(8);
         mode_ff  <= '0;
         presc_ff <= 8'd2;
         div_ff   <= '0;
         en_ff    <= 1'b0;
         half_ff  <= spims_pkg::HALF_W'(1);
      end else begin
         frame_ff <= frame_in;
         mode_ff  <= mode_in;
         presc_ff <= presc_in;
         div_ff   <= div_in;
         en_ff    <= en_in;
         half_ff  <= half_in;
      end
   end

   always_comb begin
      cfg.frame_bits = frame_ff;
      cfg.cpol       = mode_ff[1];
      cfg.cpha       = mode_ff[0];
      cfg.half_ticks = half_ff;
      cfg.enable     = en_ff;
   end

   // two stages: core state update, then capture into the output register
   assign stall     = rsp_valid_ff & ~rsp_ready;
   assign s2_adv    = s2_valid_ff & ~stall;
   assign req_ready = ~reset & (~s2_valid_ff | ~stall);
   assign accept    = req_valid & req_ready;

   assign s2_valid_in  = accept | (s2_valid_ff & ~s2_adv);
   assign rsp_valid_in = s2_adv | (rsp_valid_ff & ~rsp_ready);

   spims_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .kind       (req_kind),
      .write_data (req_write_data),
      .miso       (req_miso),
      .cfg        (cfg),
      .status     (status),
      .read_data  (core_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rsp_st_ff    <= status;
         rsp_rdata_ff <= core_rdata;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sck          = rsp_st_ff.sck;
   assign rsp_mosi         = rsp_st_ff.mosi;
   assign rsp_read_data    = rsp_rdata_ff;
   assign rsp_rx_not_empty = rsp_st_ff.rx_not_empty;
   assign rsp_tx_not_full  = rsp_st_ff.tx_not_full;
   assign rsp_busy_res     = rsp_st_ff.busy;
   assign rsp_overrun      = rsp_st_ff.overrun;

endmodule

`default_nettype wire

// ===== hw/rtl/spims_ram.sv =====
`default_nettype none

module spims_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  wire logic                                      clock,
   input  wire logic                                      we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                          wdata,
   input  wire logic                                      re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/spims_core.sv =====
`default_nettype none

module spims_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             accept,
   input  wire logic [1:0]                       kind,
   input  wire logic [spims_pkg::WORD_W-1:0]     write_data,
   input  wire logic                             miso,
   input  wire spims_pkg::spims_cfg_type         cfg,
   output spims_pkg::spims_status_type           status,
   output logic      [spims_pkg::WORD_W-1:0]     read_data
);

   logic [spims_pkg::CNT_W-1:0]   tx_cnt_ff, tx_cnt_in, rx_cnt_ff, rx_cnt_in;
   logic [spims_pkg::DEPTH_W-1:0] tx_head_ff, tx_head_in, rx_head_ff, rx_head_in;
   logic [spims_pkg::HALF_W-1:0]  tick_ff, tick_in, tick_inc;
   logic [spims_pkg::FRAME_W-1:0] bits_ff, bits_in, bits_dec, n_sat;
   logic [spims_pkg::WORD_W-1:0]  so_ff, so_in, so_eff, si_ff, si_in;
   logic [spims_pkg::SHIFT_W-1:0] lshift_ff, lshift_in;
   logic sh_ff, sh_in, active_ff, active_in, ovr_ff, ovr_in;
   logic load_pend_ff, load_pend_in, rd_pend_ff, rd_pend_in;
   logic load, finish;

   logic                          tx_we, tx_re, rx_we, rx_re;
   logic [spims_pkg::DEPTH_W-1:0] tx_waddr, rx_waddr;
   logic [spims_pkg::WORD_W-1:0]  tx_q, rx_q;

   spims_ram #(.WIDTH(spims_pkg::WORD_W), .DEPTH(spims_pkg::FIFO_DEPTH)) u_tx_ram (
      .clock (clock),
      .we    (tx_we),
      .waddr (tx_waddr),
      .wdata (write_data),
      .re    (tx_re),
      .raddr (tx_head_ff),
      .rdata (tx_q)
   );

   spims_ram #(.WIDTH(spims_pkg::WORD_W), .DEPTH(spims_pkg::FIFO_DEPTH)) u_rx_ram (
      .clock (clock),
      .we    (rx_we),
      .waddr (rx_waddr),
      .wdata (si_ff),
      .re    (rx_re),
      .raddr (rx_head_ff),
      .rdata (rx_q)
   );

   assign tx_waddr = spims_pkg::wrap_add(tx_head_ff, tx_cnt_ff);
   assign rx_waddr = spims_pkg::wrap_add(rx_head_ff, rx_cnt_ff);

   // the word fetched on a load lands in the next cycle: forward it, left aligned
   assign so_eff = load_pend_ff ? spims_pkg::WORD_W'(tx_q << lshift_ff) : so_ff;

   assign tick_inc = tick_ff + spims_pkg::HALF_W'(1);
   assign bits_dec = (bits_ff != '0) ? bits_ff - spims_pkg::FRAME_W'(1) : bits_ff;

   always_comb begin
      if (cfg.frame_bits < spims_pkg::FRAME_W'(spims_pkg::MIN_FRAME)) begin
         n_sat = spims_pkg::FRAME_W'(spims_pkg::MIN_FRAME);
      end else if (cfg.frame_bits > spims_pkg::FRAME_W'(spims_pkg::MAX_FRAME)) begin
         n_sat = spims_pkg::FRAME_W'(spims_pkg::MAX_FRAME);
      end else begin
         n_sat = cfg.frame_bits;
      end
   end

   always_comb begin
      tx_cnt_in    = tx_cnt_ff;
      rx_cnt_in    = rx_cnt_ff;
      tx_head_in   = tx_head_ff;
      rx_head_in   = rx_head_ff;
      tick_in      = tick_ff;
      bits_in      = bits_ff;
      so_in        = so_eff;
      si_in        = si_ff;
      lshift_in    = lshift_ff;
      sh_in        = sh_ff;
      active_in    = active_ff;
      ovr_in       = ovr_ff;
      load_pend_in = load_pend_ff;
      rd_pend_in   = rd_pend_ff;
      tx_we        = 1'b0;
      tx_re        = 1'b0;
      rx_we        = 1'b0;
      rx_re        = 1'b0;
      load         = 1'b0;
      finish       = 1'b0;

      if (accept) begin
         case (kind)
            spims_pkg::KIND_TICK: begin
               if (cfg.enable) begin
                  if (!active_ff) begin
                     load = (tx_cnt_ff != '0);
                  end else if (tick_inc < cfg.half_ticks) begin
                     tick_in = tick_inc;
                  end else begin
                     tick_in = '0;
                     if (!sh_ff) begin
                        si_in = {si_ff[spims_pkg::WORD_W-2:0], miso};
                        sh_in = 1'b1;
                     end else begin
                        sh_in   = 1'b0;
                        so_in   = {so_eff[spims_pkg::WORD_W-2:0], 1'b0};
                        bits_in = bits_dec;
                        finish  = (bits_dec == '0);
                     end
                  end
               end
            end
            spims_pkg::KIND_WRITE: begin
               if (tx_cnt_ff < spims_pkg::CNT_W'(spims_pkg::FIFO_DEPTH)) begin
                  tx_we     = 1'b1;
                  tx_cnt_in = tx_cnt_ff + spims_pkg::CNT_W'(1);
               end
            end
            spims_pkg::KIND_READ: begin
               if (rx_cnt_ff != '0) begin
                  rx_re      = 1'b1;
                  rx_head_in = spims_pkg::wrap_add(rx_head_ff, spims_pkg::CNT_W'(1));
                  rx_cnt_in  = rx_cnt_ff - spims_pkg::CNT_W'(1);
               end
            end
            default: ;
         endcase

         rd_pend_in = rx_re;

         if (finish) begin
            if (rx_cnt_ff < spims_pkg::CNT_W'(spims_pkg::FIFO_DEPTH)) begin
               rx_we     = 1'b1;
               rx_cnt_in = rx_cnt_ff + spims_pkg::CNT_W'(1);
            end else begin
               ovr_in = 1'b1;
            end
            active_in = 1'b0;
            load      = (tx_cnt_ff != '0);
         end

         if (load) begin
            tx_re      = 1'b1;
            tx_head_in = spims_pkg::wrap_add(tx_head_ff, spims_pkg::CNT_W'(1));
            tx_cnt_in  = tx_cnt_ff - spims_pkg::CNT_W'(1);
            lshift_in  = spims_pkg::SHIFT_W'(spims_pkg::FRAME_W'(spims_pkg::WORD_W) - n_sat);
            si_in      = '0;
            bits_in    = n_sat;
            tick_in    = '0;
            sh_in      = 1'b0;
            active_in  = 1'b1;
         end

         load_pend_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_cnt_ff    <= '0;
         rx_cnt_ff    <= '0;
         tx_head_ff   <= '0;
         rx_head_ff   <= '0;
         tick_ff      <= '0;
         bits_ff      <= '0;
         so_ff        <= '0;
         si_ff        <= '0;
         lshift_ff    <= '0;
         sh_ff        <= 1'b0;
         active_ff    <= 1'b0;
         ovr_ff       <= 1'b0;
         load_pend_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         tx_cnt_ff    <= tx_cnt_in;
         rx_cnt_ff    <= rx_cnt_in;
         tx_head_ff   <= tx_head_in;
         rx_head_ff   <= rx_head_in;
         tick_ff      <= tick_in;
         bits_ff      <= bits_in;
         so_ff        <= so_in;
         si_ff        <= si_in;
         lshift_ff    <= lshift_in;
         sh_ff        <= sh_in;
         active_ff    <= active_in;
         ovr_ff       <= ovr_in;
         load_pend_ff <= load_pend_in;
         rd_pend_ff   <= rd_pend_in;
      end
   end

   // status reflects the state left by the last accepted word
   always_comb begin
      status.sck          = active_ff ? (cfg.cpol ^ cfg.cpha ^ sh_ff) : cfg.cpol;
      status.mosi         = active_ff & so_eff[spims_pkg::WORD_W-1];
      status.rx_not_empty = (rx_cnt_ff != '0);
      status.tx_not_full  = (tx_cnt_ff < spims_pkg::CNT_W'(spims_pkg::FIFO_DEPTH));
      status.busy         = active_ff | (tx_cnt_ff != '0);
      status.overrun      = ovr_ff;
   end

   assign read_data = rd_pend_ff ? rx_q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/spims_checker.sv =====
`default_nettype none

module spims_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire logic         rsp_mosi,
   input wire logic [15:0]  rsp_read_data,
   input wire logic         rsp_tx_not_full,
   input wire logic         rsp_busy_res,
   input wire logic         rsp_overrun
);

   logic ovr_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ovr_seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_overrun) begin
         ovr_seen_ff <= 1'b1;
      end
   end

   // a stalled response holds its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) && $stable(rsp_mosi))
      else $error("response changed while stalled");

   // overrun only clears on reset
   a_ovr_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ovr_seen_ff |-> rsp_overrun)
      else $error("overrun flag dropped");

   // a full transmit FIFO means the block is busy
   a_full_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_not_full |-> rsp_busy_res)
      else $error("transmit FIFO full while not busy");

   // no frame in flight: MOSI rests low
   a_idle_mosi: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> !rsp_mosi)
      else $error("MOSI high while idle");

endmodule

bind spi_master_serializer_unit spims_checker u_spims_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_mosi         (rsp_mosi),
   .rsp_read_data    (rsp_read_data),
   .rsp_tx_not_full  (rsp_tx_not_full),
   .rsp_busy_res     (rsp_busy_res),
   .rsp_overrun      (rsp_overrun)
);

`default_nettype wire
